// ===== rtl/atomic_reservation_memory_router_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the atomic reservation memory router
// Shared shorthand for the concurrent checks inside the router's modules.
// ----------------------------------------------------------------------------
`ifndef ATOMIC_RESERVATION_MEMORY_ROUTER_UNIT_MACROS_SVH
`define ATOMIC_RESERVATION_MEMORY_ROUTER_UNIT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ARMU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define ARMU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/armu_pkg.sv =====
// ----------------------------------------------------------------------------
// armu_pkg
// Types and constants shared by the router's front end, queue and back end.
// ----------------------------------------------------------------------------
package armu_pkg;

  localparam int ARMU_CORES            = 4;
  localparam int ARMU_STORE_WORDS_LOG2 = 14;
  localparam int CORE_IDX_W            = 4;   // holds any core count up to 15
  localparam int QUEUE_DEPTH           = 2;

  localparam logic [3:0]  LANE_ALL     = 4'hF;
  localparam logic [31:0] SC_FAIL_CODE = 32'h1;
  localparam logic [16:0] SIZE_RESET   = 17'h10000;

  // configuration register indexes
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;

  // access kinds as they arrive on the input
  localparam logic [1:0] KIND_FETCH = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_WRITE = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_FETCH = 2'd1,
    OP_READ  = 2'd2,
    OP_WRITE = 2'd3
  } op_t;

  // classified item as it waits for the back end
  typedef struct packed {
    op_t         op;
    logic [1:0]  requester;
    logic [31:0] address;
    logic [31:0] write_data;
    logic [3:0]  lanes;
    logic        reserve;
    logic        atomic;
    logic [31:0] bus_data;
    logic        internal;
    logic [31:0] offset;
  } item_t;

endpackage

// ===== rtl/armu_front.sv =====
// ----------------------------------------------------------------------------
// armu_front
// Classify an incoming access: operation, window hit and window offset.
// ----------------------------------------------------------------------------
module armu_front #(
  parameter int CORES = 4
) (
  input  logic [1:0]          kind,
  input  logic [1:0]          requester,
  input  logic [31:0]         address,
  input  logic [31:0]         write_data,
  input  logic [3:0]          byte_select,
  input  logic                reserve_flag,
  input  logic                atomic_flag,
  input  logic [31:0]         bus_read_data,
  input  logic [31:0]         base,
  input  logic [16:0]         size,
  output armu_pkg::item_t     item
);
  import armu_pkg::*;

  logic [31:0] offset;
  logic        core_ok;

  assign offset  = address - base;
  assign core_ok = {{(CORE_IDX_W - 2){1'b0}}, requester} < CORE_IDX_W'(CORES);

  always_comb begin
    item            = '0;
    item.requester  = requester;
    item.address    = address;
    item.write_data = write_data;
    item.lanes      = byte_select & LANE_ALL;
    item.reserve    = reserve_flag;
    item.atomic     = atomic_flag;
    item.bus_data   = bus_read_data;
    item.offset     = offset;
    item.internal   = offset < {15'b0, size};
    item.op         = OP_NONE;
    if (core_ok) begin
      case (kind)
        KIND_FETCH: item.op = OP_FETCH;
        KIND_READ:  item.op = OP_READ;
        KIND_WRITE: item.op = OP_WRITE;
        default:    item.op = OP_NONE;
      endcase
    end
  end

endmodule

// ===== rtl/armu_queue.sv =====
// ----------------------------------------------------------------------------
// armu_queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
`include "atomic_reservation_memory_router_unit_macros.svh"

module armu_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  armu_pkg::item_t  push_item,
  output logic             full,
  input  logic             pop,
  output logic             q_valid,
  output armu_pkg::item_t  q_item
);
  import armu_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = count_r == CW'(QUEUE_DEPTH);
  assign q_valid = count_r != '0;
  assign q_item  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  `ARMU_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
  `ARMU_ASSERT_IMP(a_no_pop_empty, pop, q_valid, "pop from empty queue")
  `ARMU_ASSERT_IMP(a_count_max, 1'b1, count_r <= CW'(QUEUE_DEPTH), "queue count out of range")

endmodule

// ===== rtl/armu_back.sv =====
// ----------------------------------------------------------------------------
// armu_back
// Execute one item: reservation and pending bookkeeping, word memory, result.
// ----------------------------------------------------------------------------
`include "atomic_reservation_memory_router_unit_macros.svh"

module armu_back #(
  parameter int CORES            = 4,
  parameter int STORE_WORDS_LOG2 = 14
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  armu_pkg::item_t  q_item,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [31:0]      out_read_data,
  output logic             out_served,
  output logic             out_went_external,
  output logic             out_sc_failed
);
  import armu_pkg::*;

  localparam int DEPTH = 1 << STORE_WORDS_LOG2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  item_t  item_r;

  logic [31:0] resv_addr_r  [CORES];
  logic [31:0] resv_addr_nxt[CORES];
  logic [CORES-1:0] resv_valid_r, resv_valid_nxt;
  logic [31:0] pend_addr_r  [CORES];
  logic [31:0] pend_addr_nxt[CORES];
  logic [CORES-1:0] pend_r, pend_nxt;

  logic [31:0] mem [DEPTH];
  logic [31:0] mem_q;
  logic [STORE_WORDS_LOG2-1:0] idx;

  logic        blocked, own_valid, is_self;
  logic        served_c, ext_c, scfail_c, use_mem_c, mem_we_c;
  logic [31:0] data_c;
  logic        res_served_r, res_ext_r, res_scfail_r, res_use_mem_r;
  logic [31:0] res_data_r;

  logic        out_valid_r;
  logic [31:0] out_read_data_r;
  logic        out_served_r, out_went_external_r, out_sc_failed_r;
  logic        out_free, exec;

  assign idx      = item_r.offset[2 +: STORE_WORDS_LOG2];
  assign exec     = state_r == ST_EXEC;
  assign out_free = !out_valid_r || !out_stall;
  assign pop      = q_valid && ((state_r == ST_IDLE) || ((state_r == ST_FIN) && out_free));

  // pending-atomic conflict and own reservation lookup
  always_comb begin
    blocked   = 1'b0;
    own_valid = 1'b0;
    is_self   = 1'b0;
    for (int j = 0; j < CORES; j++) begin
      is_self = {{(CORE_IDX_W - 2){1'b0}}, item_r.requester} == CORE_IDX_W'(j);
      if (!is_self && pend_r[j] && (pend_addr_r[j] == item_r.address)) begin
        blocked = 1'b1;
      end
      if (is_self) begin
        own_valid = resv_valid_r[j];
      end
    end
  end

  // result of the item in execution
  always_comb begin
    served_c  = 1'b0;
    ext_c     = 1'b0;
    scfail_c  = 1'b0;
    use_mem_c = 1'b0;
    mem_we_c  = 1'b0;
    data_c    = '0;
    case (item_r.op)
      OP_FETCH, OP_READ: begin
        if ((item_r.op == OP_FETCH) || !blocked) begin
          served_c = 1'b1;
          if (item_r.internal) begin
            use_mem_c = 1'b1;
          end else begin
            ext_c  = 1'b1;
            data_c = item_r.bus_data;
          end
        end
      end
      OP_WRITE: begin
        if (!blocked) begin
          served_c = 1'b1;
          if (item_r.reserve && !own_valid) begin
            scfail_c = 1'b1;
            data_c   = SC_FAIL_CODE;
          end else if (item_r.internal) begin
            mem_we_c = 1'b1;
          end else begin
            ext_c = 1'b1;
          end
        end
      end
      default: begin
        served_c = 1'b0;
      end
    endcase
  end

  // reservation and pending updates
  always_comb begin
    resv_valid_nxt = resv_valid_r;
    pend_nxt       = pend_r;
    for (int j = 0; j < CORES; j++) begin
      resv_addr_nxt[j] = resv_addr_r[j];
      pend_addr_nxt[j] = pend_addr_r[j];
      if ({{(CORE_IDX_W - 2){1'b0}}, item_r.requester} == CORE_IDX_W'(j)) begin
        if ((item_r.op == OP_READ) && !blocked) begin
          if (item_r.reserve) begin
            resv_addr_nxt[j]  = item_r.address;
            resv_valid_nxt[j] = 1'b1;
          end else if (item_r.atomic) begin
            pend_nxt[j]      = 1'b1;
            pend_addr_nxt[j] = item_r.address;
          end
        end
      end
      if ((item_r.op == OP_WRITE) && (resv_addr_r[j] == item_r.address)) begin
        resv_valid_nxt[j] = 1'b0;
      end
      if ({{(CORE_IDX_W - 2){1'b0}}, item_r.requester} == CORE_IDX_W'(j)) begin
        if ((item_r.op == OP_WRITE) && !blocked) begin
          if (item_r.reserve) begin
            resv_valid_nxt[j] = 1'b0;
          end else if (item_r.atomic) begin
            pend_nxt[j] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_nxt = q_valid ? ST_EXEC : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      resv_valid_r <= '0;
      pend_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int j = 0; j < CORES; j++) begin
        resv_addr_r[j] <= '0;
        pend_addr_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        resv_valid_r <= resv_valid_nxt;
        pend_r       <= pend_nxt;
        for (int j = 0; j < CORES; j++) begin
          resv_addr_r[j] <= resv_addr_nxt[j];
          pend_addr_r[j] <= pend_addr_nxt[j];
        end
      end
      if ((state_r == ST_FIN) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= q_item;
    end
    if (exec) begin
      res_served_r  <= served_c;
      res_ext_r     <= ext_c;
      res_scfail_r  <= scfail_c;
      res_use_mem_r <= use_mem_c;
      res_data_r    <= data_c;
    end
    if ((state_r == ST_FIN) && out_free) begin
      out_read_data_r     <= res_use_mem_r ? mem_q : res_data_r;
      out_served_r        <= res_served_r;
      out_went_external_r <= res_ext_r;
      out_sc_failed_r     <= res_scfail_r;
    end
  end

  // word memory with byte lane writes and registered read
  always_ff @(posedge clk) begin
    if (exec) begin
      if (mem_we_c) begin
        for (int b = 0; b < 4; b++) begin
          if (item_r.lanes[b]) begin
            mem[idx][8*b +: 8] <= item_r.write_data[8*b +: 8];
          end
        end
      end
      mem_q <= mem[idx];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_data     = out_read_data_r;
  assign out_served        = out_served_r;
  assign out_went_external = out_went_external_r;
  assign out_sc_failed     = out_sc_failed_r;

  `ARMU_ASSERT_NXT(a_exec_to_fin, state_r == ST_EXEC, state_r == ST_FIN,
                   "exec not followed by fin")
  `ARMU_ASSERT_IMP(a_sc_fail_shape, out_valid_r && out_sc_failed_r,
                   out_served_r && !out_went_external_r && (out_read_data_r == SC_FAIL_CODE),
                   "bad store-conditional failure result")
  `ARMU_ASSERT_IMP(a_pop_when_free, pop, (state_r == ST_IDLE) || (state_r == ST_FIN),
                   "pop while executing")

endmodule

// ===== rtl/atomic_reservation_memory_router_unit.sv =====
// ----------------------------------------------------------------------------
// atomic_reservation_memory_router_unit
// Routes core accesses to an internal word memory or the external bus and
// tracks load-reserved reservations and pending atomics per core.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------
//   in_     | input     | in_valid/in_stall  | kind, requester, address, ... bus
//   out_    | output    | out_valid/out_stall| read_data, served, external, sc
//   cfg_    | input     | cfg_we             | cfg_index, cfg_wdata
//
// An item passes through ST_EXEC, to check reservations and pending atomics
// and to access the word memory, then ST_FIN, to collect the registered
// memory read word; the next item enters only as ST_FIN hands on its result.
// The front end classifies and queues up to two items while the back end or
// the output register is stalled. Reset is synchronous and clears the queue,
// reservations, pending marks and config (base 0, size 64 KiB); the word
// memory itself is not cleared.
// ----------------------------------------------------------------------------
module atomic_reservation_memory_router_unit #(
  parameter int CORES            = armu_pkg::ARMU_CORES,
  parameter int STORE_WORDS_LOG2 = armu_pkg::ARMU_STORE_WORDS_LOG2
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [1:0]  in_requester,
  input  logic [31:0] in_address,
  input  logic [31:0] in_write_data,
  input  logic [3:0]  in_byte_select,
  input  logic        in_reserve_flag,
  input  logic        in_atomic_flag,
  input  logic [31:0] in_bus_read_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_read_data,
  output logic        out_served,
  output logic        out_went_external,
  output logic        out_sc_failed
);
  import armu_pkg::*;

  logic [31:0] base_r;
  logic [16:0] size_r;
  item_t       front_item, q_item;
  logic        q_full, q_valid, push, pop;

  // config registers; the user must write them only while idle (not enforced here)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE: base_r <= cfg_wdata;
        CFG_SIZE: size_r <= cfg_wdata[16:0];
        default:  base_r <= base_r;
      endcase
    end
  end

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  armu_front #(
    .CORES(CORES)
  ) u_front (
    .kind          (in_kind),
    .requester     (in_requester),
    .address       (in_address),
    .write_data    (in_write_data),
    .byte_select   (in_byte_select),
    .reserve_flag  (in_reserve_flag),
    .atomic_flag   (in_atomic_flag),
    .bus_read_data (in_bus_read_data),
    .base          (base_r),
    .size          (size_r),
    .item          (front_item)
  );

  armu_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  armu_back #(
    .CORES            (CORES),
    .STORE_WORDS_LOG2 (STORE_WORDS_LOG2)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_data     (out_read_data),
    .out_served        (out_served),
    .out_went_external (out_went_external),
    .out_sc_failed     (out_sc_failed)
  );

endmodule
